FILE: hdl/cilu_pkg.sv
`timescale 1ns / 1ps
package cilu_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int PTR_MOD = 2 * QUEUE_DEPTH;
	localparam int PTR_W = $clog2(PTR_MOD);
	localparam int ADDR_W = $clog2(QUEUE_DEPTH);

	// op queue between front and back, power of two
	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_AW = $clog2(OPQ_DEPTH);

	localparam logic CMD_RECEIVE = 1'b0;
	localparam logic CMD_POP = 1'b1;

	localparam logic [7:0] KEY_NUL = 8'h00;
	localparam logic [7:0] KEY_CTRL_D = 8'h04;
	localparam logic [7:0] KEY_CTRL_H = 8'h08;
	localparam logic [7:0] KEY_TAB = 8'h09;
	localparam logic [7:0] KEY_LF = 8'h0a;
	localparam logic [7:0] KEY_CR = 8'h0d;
	localparam logic [7:0] KEY_CTRL_P = 8'h10;
	localparam logic [7:0] KEY_ESC = 8'h1b;
	localparam logic [7:0] KEY_SPACE = 8'h20;
	localparam logic [7:0] KEY_BRACKET = 8'h5b;
	localparam logic [7:0] KEY_DEL = 8'h7f;

	localparam logic [2:0] KIND_ECHO = 3'd0;
	localparam logic [2:0] KIND_READ = 3'd1;
	localparam logic [2:0] KIND_EOF = 3'd2;
	localparam logic [2:0] KIND_EMPTY = 3'd3;
	localparam logic [2:0] KIND_PROCLIST = 3'd4;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic       first_of_read;
	} req_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       read_done;
		logic       last;
	} rsp_t;

	typedef enum logic [1:0] {OP_PROCLIST, OP_STORE, OP_POP} op_code_t;
	typedef enum logic [1:0] {ECHO_NONE, ECHO_SELF, ECHO_ERASE} echo_t;

	typedef struct packed {
		op_code_t   code;
		logic [7:0] char_v;
		echo_t      echo;
		logic       first;
	} op_t;

	typedef enum logic [1:0] {ESC_NONE, ESC_GOT_ESC, ESC_GOT_CSI} esc_state_t;
	typedef enum logic [1:0] {BK_IDLE, BK_READ, BK_EMIT} back_state_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(PTR_MOD - 1)) ? '0 : p + 1'b1;
	endfunction

	// pointer counts modulo twice the depth, fold it back onto the store
	function automatic logic [ADDR_W-1:0] ptr_addr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] folded;
		folded = (p >= PTR_W'(QUEUE_DEPTH)) ? p - PTR_W'(QUEUE_DEPTH) : p;
		return folded[ADDR_W-1:0];
	endfunction

endpackage

FILE: hdl/console_input_line_discipline_unit.sv
`timescale 1ns / 1ps
// Console receive line discipline. Requests enter through push/full: a received byte
// (cmd 0) or a read of one byte (cmd 1). The front classifies each item in the cycle it
// is accepted, tracks escape sequences and drops NUL, then hands an operation to a
// four-entry op queue, so the front takes one item per cycle until that queue fills.
// The back owns the ring queue memory and the result register and runs one operation
// at a time: a received byte gives 0, 1 or 3 echo results, a control-P one result,
// a read steps through memory read, registered read data and result load, or goes
// straight to the result when the queue is empty; results are taken through empty/pop,
// the last result of an item carrying last. The back stalls only when a result waits.
module console_input_line_discipline_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  cilu_pkg::req_t req,
	output logic           empty,
	input  logic           pop,
	output cilu_pkg::rsp_t rsp
);
	import cilu_pkg::*;

	op_t  fr_op;
	op_t  bk_op;
	logic fr_push;
	logic opq_full;
	logic opq_empty;
	logic bk_pop;

	cilu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req     (req),
		.op_push (fr_push),
		.op_full (opq_full),
		.op      (fr_op)
	);

	cilu_fifo u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.full   (opq_full),
		.wdata  (fr_op),
		.pop    (bk_pop),
		.empty  (opq_empty),
		.rdata  (bk_op)
	);

	cilu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (opq_empty),
		.op_pop   (bk_pop),
		.op       (bk_op),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

FILE: hdl/cilu_fifo.sv
`timescale 1ns / 1ps
module cilu_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  cilu_pkg::op_t wdata,
	input  logic          pop,
	output logic          empty,
	output cilu_pkg::op_t rdata
);
	import cilu_pkg::*;

	op_t              entry_q [OPQ_DEPTH];
	logic [OPQ_AW-1:0] wr_q;
	logic [OPQ_AW-1:0] rd_q;
	logic [OPQ_AW:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full = count_q == (OPQ_AW + 1)'(OPQ_DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_q] <= wdata;
	end

endmodule

FILE: hdl/cilu_front.sv
`timescale 1ns / 1ps
module cilu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  cilu_pkg::req_t req,
	output logic           op_push,
	input  logic           op_full,
	output cilu_pkg::op_t  op
);
	import cilu_pkg::*;

	esc_state_t esc_q;
	esc_state_t esc_d;
	logic [7:0] c;
	logic       accept;
	logic       is_recv;
	logic       is_ctrl_p;
	logic       is_nul;
	logic       quiet;

	assign full = op_full;
	assign accept = push && !op_full;
	assign is_recv = req.cmd == CMD_RECEIVE;
	assign is_ctrl_p = req.rx_byte == KEY_CTRL_P;
	assign is_nul = req.rx_byte == KEY_NUL;
	assign c = (req.rx_byte == KEY_CR) ? KEY_LF : req.rx_byte;

	// escape tracker, advances only on bytes that reach the queue
	always_comb begin
		esc_d = esc_q;
		if (accept && is_recv && !is_ctrl_p && !is_nul) begin
			case (esc_q)
				ESC_NONE: begin
					if (c == KEY_ESC)
						esc_d = ESC_GOT_ESC;
				end
				ESC_GOT_ESC: begin
					esc_d = (c == KEY_BRACKET) ? ESC_GOT_CSI : ESC_NONE;
				end
				ESC_GOT_CSI: begin
					esc_d = ESC_NONE;
				end
				default: begin
					esc_d = ESC_NONE;
				end
			endcase
		end
	end

	always_comb begin
		case (esc_q)
			ESC_NONE: begin
				quiet = c == KEY_ESC;
			end
			default: begin
				quiet = 1'b1;
			end
		endcase
	end

	always_comb begin
		op.char_v = c;
		op.first = req.first_of_read;
		if (!is_recv)
			op.code = OP_POP;
		else if (is_ctrl_p)
			op.code = OP_PROCLIST;
		else
			op.code = OP_STORE;
		if (quiet || c == KEY_TAB)
			op.echo = ECHO_NONE;
		else if (c inside {KEY_DEL, KEY_CTRL_H})
			op.echo = ECHO_ERASE;
		else
			op.echo = ECHO_SELF;
	end

	// nul is dropped here and never reaches the back
	assign op_push = accept && !(is_recv && is_nul);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			esc_q <= ESC_NONE;
		else
			esc_q <= esc_d;
	end

endmodule

FILE: hdl/cilu_back.sv
`timescale 1ns / 1ps
module cilu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_empty,
	output logic           op_pop,
	input  cilu_pkg::op_t  op,
	output logic           empty,
	input  logic           pop,
	output cilu_pkg::rsp_t rsp
);
	import cilu_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [7:0]        mem [QUEUE_DEPTH];
	logic [7:0]        rd_q;
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  wptr_d;
	logic [PTR_W-1:0]  rptr_q;
	logic [PTR_W-1:0]  rptr_d;
	logic [PTR_W-1:0]  rptr_inc;
	logic [PTR_W:0]    occ;
	logic              q_full;
	logic              q_empty;
	logic              op_valid;
	logic              mem_we;
	logic              rd_en;
	logic              out_ld;
	logic              first_q;
	logic              first_d;
	logic [2:0]        res_kind_q;
	logic [2:0]        res_kind_d;
	logic [7:0]        res_data_q;
	logic [7:0]        res_data_d;
	logic              res_done_q;
	logic              res_done_d;
	logic              erase_q;
	logic              erase_d;
	logic [1:0]        cnt_q;
	logic [1:0]        cnt_d;
	logic [1:0]        idx_q;
	logic [1:0]        idx_d;
	rsp_t              out_q;
	rsp_t              out_d;
	logic              out_valid_q;

	assign op_valid = !op_empty;
	assign occ = (wptr_q >= rptr_q) ? {1'b0, wptr_q} - {1'b0, rptr_q}
		: {1'b0, wptr_q} + (PTR_W + 1)'(PTR_MOD) - {1'b0, rptr_q};
	assign q_full = occ == (PTR_W + 1)'(QUEUE_DEPTH);
	assign q_empty = rptr_q == wptr_q;
	assign rptr_inc = ptr_next(rptr_q);
	assign out_ld = (state_q == BK_EMIT) && (!out_valid_q || pop);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (op_valid) begin
					case (op.code)
						OP_PROCLIST: state_d = BK_EMIT;
						OP_STORE:    state_d = (op.echo == ECHO_NONE) ? BK_IDLE : BK_EMIT;
						OP_POP:      state_d = q_empty ? BK_EMIT : BK_READ;
						default:     state_d = BK_IDLE;
					endcase
				end
			end
			BK_READ: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (out_ld && idx_q == cnt_q)
					state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		op_pop = 1'b0;
		mem_we = 1'b0;
		rd_en = 1'b0;
		wptr_d = wptr_q;
		rptr_d = rptr_q;
		first_d = first_q;
		res_kind_d = res_kind_q;
		res_data_d = res_data_q;
		res_done_d = res_done_q;
		erase_d = erase_q;
		cnt_d = cnt_q;
		idx_d = idx_q;
		case (state_q)
			BK_IDLE: begin
				if (op_valid) begin
					op_pop = 1'b1;
					idx_d = 2'd0;
					cnt_d = 2'd0;
					erase_d = 1'b0;
					res_data_d = 8'd0;
					res_done_d = 1'b0;
					case (op.code)
						OP_PROCLIST: begin
							res_kind_d = KIND_PROCLIST;
						end
						OP_STORE: begin
							if (!q_full) begin
								mem_we = 1'b1;
								wptr_d = ptr_next(wptr_q);
							end
							res_kind_d = KIND_ECHO;
							res_data_d = op.char_v;
							// backspace, space, backspace
							if (op.echo == ECHO_ERASE) begin
								cnt_d = 2'd2;
								erase_d = 1'b1;
							end
						end
						OP_POP: begin
							first_d = op.first;
							res_kind_d = KIND_EMPTY;
							res_done_d = 1'b1;
							if (!q_empty)
								rd_en = 1'b1;
						end
						default: begin
							op_pop = 1'b1;
						end
					endcase
				end
			end
			BK_READ: begin
				if (rd_q == KEY_CTRL_D) begin
					// end of file stays queued unless it opens the read call
					res_kind_d = KIND_EOF;
					res_data_d = 8'd0;
					res_done_d = 1'b1;
					if (first_q)
						rptr_d = rptr_inc;
				end else begin
					rptr_d = rptr_inc;
					res_kind_d = KIND_READ;
					res_data_d = rd_q;
					res_done_d = (rd_q == KEY_LF) || (rptr_inc == wptr_q);
				end
			end
			BK_EMIT: begin
				if (out_ld)
					idx_d = idx_q + 2'd1;
			end
			default: begin
				idx_d = 2'd0;
			end
		endcase
	end

	always_comb begin
		out_d.kind = res_kind_q;
		out_d.data = erase_q ? ((idx_q == 2'd1) ? KEY_SPACE : KEY_CTRL_H) : res_data_q;
		out_d.read_done = res_done_q;
		out_d.last = idx_q == cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			wptr_q <= '0;
			rptr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wptr_q <= wptr_d;
			rptr_q <= rptr_d;
			if (out_ld)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		first_q <= first_d;
		res_kind_q <= res_kind_d;
		res_data_q <= res_data_d;
		res_done_q <= res_done_d;
		erase_q <= erase_d;
		cnt_q <= cnt_d;
		idx_q <= idx_d;
		if (out_ld)
			out_q <= out_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[ptr_addr(wptr_q)] <= op.char_v;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= mem[ptr_addr(rptr_q)];
	end

	assign empty = !out_valid_q;
	assign rsp = out_q;

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (PTR_W + 1)'(QUEUE_DEPTH))
		else $error("queue occupancy beyond depth");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !q_full)
		else $error("store written while full");
	a_read_issued: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_READ |-> $past(rd_en))
		else $error("read state without a memory read");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_EMIT |-> idx_q <= cnt_q)
		else $error("result index past last result");
`endif

endmodule
